[hw/rtl/pmc_pkg.sv]
// Shared types, command codes and helpers for the point motor controller.
package pmc_pkg;

    localparam int ROUTE_SLOTS_DEF = 8;

    localparam logic [15:0] DEVICE_LOCK_ID = 16'd9999;

    localparam logic [2:0] CMD_POLL       = 3'd0;
    localparam logic [2:0] CMD_ACTIVATE   = 3'd1;
    localparam logic [2:0] CMD_ACT_ROUTE  = 3'd2;
    localparam logic [2:0] CMD_LOCK_DEV   = 3'd3;
    localparam logic [2:0] CMD_LOCK_ROUTE = 3'd4;
    localparam logic [2:0] CMD_LOAD_ENTRY = 3'd5;

    localparam logic [2:0] CFG_DEVICE_ID  = 3'd0;
    localparam logic [2:0] CFG_MOTOR_SWAP = 3'd1;
    localparam logic [2:0] CFG_INPUT_SWAP = 3'd2;
    localparam logic [2:0] CFG_PORT_HALF  = 3'd3;
    localparam logic [2:0] CFG_SETTLE_MS  = 3'd4;

    localparam logic [2:0] POS_UNKNOWN      = 3'd0;
    localparam logic [2:0] POS_NORMAL       = 3'd1;
    localparam logic [2:0] POS_DIVERGING    = 3'd2;
    localparam logic [2:0] POS_MOVING_NORM  = 3'd3;
    localparam logic [2:0] POS_MOVING_DIV   = 3'd4;

    localparam logic [2:0] LOCK_FLAG_OFF = 3'd0;
    localparam logic [2:0] LOCK_FLAG_ON  = 3'd1;

    localparam logic [15:0] SETTLE_MS_RESET = 16'd100;

    typedef struct packed {
        logic        valid;
        logic [15:0] tid;
        logic        found;
        logic [2:0]  state;
    } t_query;

    typedef struct packed {
        logic        we;
        logic [2:0]  index;
        logic [15:0] id;
        logic [2:0]  state;
    } t_route_wr;

    function automatic logic [2:0] normalize(input logic [2:0] s);
        logic [2:0] r;
        r = POS_UNKNOWN;
        if (s == POS_NORMAL || s == POS_MOVING_NORM) begin
            r = POS_NORMAL;
        end else if (s == POS_DIVERGING || s == POS_MOVING_DIV) begin
            r = POS_DIVERGING;
        end
        return r;
    endfunction

endpackage

[hw/rtl/pmc_route_cell.sv]
// One route table slot: holds an entry and passes the search query to its neighbor.
module pmc_route_cell #(
    parameter int INDEX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmc_pkg::t_query    i_query,
    input  pmc_pkg::t_route_wr i_wr,
    output pmc_pkg::t_query    o_query
);
    import pmc_pkg::*;

    logic [15:0] r_id;
    logic [2:0]  r_state;
    logic        r_valid;
    logic [15:0] r_tid;
    logic        r_found;
    logic [2:0]  r_hit_state;

    logic        match;
    logic        n_found;
    logic [2:0]  n_hit_state;

    assign match       = i_query.valid && !i_query.found && (i_query.tid == r_id);
    assign n_found     = i_query.found || match;
    assign n_hit_state = match ? r_state : i_query.state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id    <= '0;
            r_state <= POS_UNKNOWN;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_query.valid;
            if (i_wr.we && (int'(i_wr.index) == INDEX)) begin
                r_id    <= i_wr.id;
                r_state <= i_wr.state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tid       <= i_query.tid;
        r_found     <= n_found;
        r_hit_state <= n_hit_state;
    end

    assign o_query = '{valid: r_valid, tid: r_tid, found: r_found, state: r_hit_state};

endmodule

[hw/rtl/pmc_ctrl.sv]
// Command sequencer, configuration registers and point state for the point motor controller.
module pmc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_data,
    input  logic               start,
    input  logic [2:0]         i_cmd,
    input  logic [7:0]         i_port_in,
    input  logic [31:0]        i_now_ms,
    input  logic [15:0]        i_target_id,
    input  logic [2:0]         i_req_field,
    input  logic [2:0]         i_entry_index,
    input  pmc_pkg::t_query    i_route,
    output logic               busy,
    output pmc_pkg::t_route_wr o_wr,
    output logic               o_done,
    output logic [7:0]         o_port_out,
    output logic               o_report,
    output logic [2:0]         o_reported_state,
    output logic               o_is_locked
);
    import pmc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } t_fsm;

    t_fsm        r_fsm, n_fsm;

    logic [15:0] r_device_id;
    logic        r_motor_swap;
    logic        r_input_swap;
    logic        r_port_half;
    logic [15:0] r_settle_ms;

    logic [2:0]  r_cmd;
    logic [7:0]  r_port;
    logic [31:0] r_now;
    logic [15:0] r_tid;
    logic [2:0]  r_req;
    logic [2:0]  r_idx;

    logic [7:0]  r_drive, n_drive;
    logic [2:0]  r_last, n_last;
    logic [2:0]  r_position, n_position;
    logic [31:0] r_change, n_change;
    logic [15:0] r_lock, n_lock;

    logic        r_done;
    logic [7:0]  r_port_out, n_port_out;
    logic        r_report, n_report;

    logic        accept;
    logic        finish;
    logic [3:0]  a4, b4, nib;
    logic [7:0]  m_a, m_b;
    logic        fb_n, fb_d;
    logic [2:0]  cur;
    logic [31:0] elapsed;
    logic        settled;
    logic [2:0]  route_want;
    logic [2:0]  want;
    logic [15:0] lock_mid;
    logic [15:0] new_lock;

    assign accept = start && (r_fsm == ST_IDLE);
    assign finish = (r_fsm == ST_SEARCH) && i_route.valid;
    assign busy   = (r_fsm == ST_SEARCH);

    assign a4  = r_motor_swap ? 4'b0010 : 4'b0001;
    assign b4  = r_motor_swap ? 4'b0001 : 4'b0010;
    assign m_a = r_port_half ? {a4, 4'b0000} : {4'b0000, a4};
    assign m_b = r_port_half ? {b4, 4'b0000} : {4'b0000, b4};
    assign nib = r_port_half ? r_port[7:4] : r_port[3:0];
    assign fb_n = r_input_swap ? nib[3] : nib[2];
    assign fb_d = r_input_swap ? nib[2] : nib[3];
    assign cur  = !fb_n ? POS_NORMAL : (!fb_d ? POS_DIVERGING : POS_UNKNOWN);

    assign elapsed    = r_now - r_change;
    assign settled    = elapsed > {16'b0, r_settle_ms};
    assign route_want = i_route.found ? normalize(i_route.state) : POS_UNKNOWN;

    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            ST_IDLE:   if (accept) n_fsm = ST_SEARCH;
            ST_SEARCH: if (i_route.valid) n_fsm = ST_IDLE;
            default:   n_fsm = ST_IDLE;
        endcase
    end

    always_comb begin
        n_position = r_position;
        n_last     = r_last;
        n_change   = r_change;
        n_drive    = r_drive;
        n_port_out = r_port;
        n_report   = 1'b0;
        want       = POS_UNKNOWN;
        lock_mid   = r_lock;
        new_lock   = '0;
        o_wr       = '{we: 1'b0, index: r_idx, id: r_tid, state: r_req};

        case (r_cmd)
            CMD_POLL: begin
                if (cur != POS_UNKNOWN && settled && cur == r_last && r_last != r_position) begin
                    n_change = r_now;
                    if (!((r_position == POS_MOVING_DIV && cur == POS_NORMAL) ||
                          (r_position == POS_MOVING_NORM && cur == POS_DIVERGING))) begin
                        n_position = cur;
                        n_report   = 1'b1;
                    end
                end
                n_port_out = (r_port & ~(m_a | m_b)) | (r_drive & (m_a | m_b));
                n_last     = cur;
            end
            CMD_ACTIVATE: begin
                if (r_tid == r_device_id) begin
                    if (r_req == POS_UNKNOWN) begin
                        want = (r_position == POS_NORMAL || r_position == POS_MOVING_NORM) ?
                               POS_DIVERGING : POS_NORMAL;
                    end else begin
                        want = normalize(r_req);
                    end
                end
            end
            CMD_ACT_ROUTE: begin
                want = route_want;
            end
            CMD_LOCK_DEV: begin
                if (r_tid == r_device_id) begin
                    lock_mid = (r_req == LOCK_FLAG_ON) ? DEVICE_LOCK_ID : '0;
                end
            end
            CMD_LOCK_ROUTE: begin
                want = route_want;
                if (want != POS_UNKNOWN) begin
                    if (r_req == LOCK_FLAG_OFF) begin
                        if (r_lock == r_tid) lock_mid = '0;
                        want = POS_UNKNOWN;
                    end else if (r_lock == '0) begin
                        new_lock = r_tid;
                    end
                end
            end
            CMD_LOAD_ENTRY: begin
                o_wr.we = finish;
            end
            default: ;
        endcase

        if (lock_mid == '0 && want != POS_UNKNOWN && want != r_position) begin
            if (want == POS_DIVERGING) begin
                n_port_out = (r_port | m_a) & ~m_b;
                n_position = POS_MOVING_DIV;
            end else begin
                n_port_out = (r_port & ~m_a) | m_b;
                n_position = POS_MOVING_NORM;
            end
            n_drive  = n_port_out;
            n_report = 1'b1;
        end

        n_lock = (lock_mid == '0) ? new_lock : lock_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= ST_IDLE;
            r_done       <= 1'b0;
            r_device_id  <= '0;
            r_motor_swap <= 1'b0;
            r_input_swap <= 1'b0;
            r_port_half  <= 1'b0;
            r_settle_ms  <= SETTLE_MS_RESET;
            r_drive      <= '0;
            r_last       <= POS_UNKNOWN;
            r_position   <= POS_UNKNOWN;
            r_change     <= '0;
            r_lock       <= '0;
        end else begin
            r_fsm  <= n_fsm;
            r_done <= finish;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DEVICE_ID:  r_device_id  <= i_cfg_data;
                    CFG_MOTOR_SWAP: r_motor_swap <= i_cfg_data[0];
                    CFG_INPUT_SWAP: r_input_swap <= i_cfg_data[0];
                    CFG_PORT_HALF:  r_port_half  <= i_cfg_data[0];
                    CFG_SETTLE_MS:  r_settle_ms  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (finish) begin
                r_drive    <= n_drive;
                r_last     <= n_last;
                r_position <= n_position;
                r_change   <= n_change;
                r_lock     <= n_lock;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_port <= i_port_in;
            r_now  <= i_now_ms;
            r_tid  <= i_target_id;
            r_req  <= i_req_field;
            r_idx  <= i_entry_index;
        end
        if (finish) begin
            r_port_out <= n_port_out;
            r_report   <= n_report;
        end
    end

    assign o_done           = r_done;
    assign o_port_out       = r_port_out;
    assign o_report         = r_report && r_done;
    assign o_reported_state = r_position;
    assign o_is_locked      = |r_lock;

endmodule

[hw/rtl/point_motor_controller_top.sv]
// Top level of the point motor controller: route cell chain and command sequencer.
// The query walks one route cell per cycle; no new start is taken while a command is in progress.
// busy is high while the query runs; a new start is taken in the cycle o_done is shown.
// Results are valid for the single o_done cycle; the receiver cannot stall.
// Synchronous active-low reset clears the point state, the locks, the route table and config.
module point_motor_controller_top #(
    parameter int ROUTE_SLOTS = pmc_pkg::ROUTE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_port_in,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_target_id,
    input  logic [2:0]  i_req_field,
    input  logic [2:0]  i_entry_index,
    output logic        o_done,
    output logic [7:0]  o_port_out,
    output logic        o_report,
    output logic [2:0]  o_reported_state,
    output logic        o_is_locked
);
    import pmc_pkg::*;

    t_query    w_link [ROUTE_SLOTS+1];
    t_route_wr w_wr;

    assign w_link[0] = '{valid: start && !busy, tid: i_target_id, found: 1'b0,
                         state: POS_UNKNOWN};

    for (genvar g = 0; g < ROUTE_SLOTS; g++) begin : g_cell
        pmc_route_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_query (w_link[g]),
            .i_wr    (w_wr),
            .o_query (w_link[g+1])
        );
    end

    pmc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .i_cmd            (i_cmd),
        .i_port_in        (i_port_in),
        .i_now_ms         (i_now_ms),
        .i_target_id      (i_target_id),
        .i_req_field      (i_req_field),
        .i_entry_index    (i_entry_index),
        .i_route          (w_link[ROUTE_SLOTS]),
        .busy             (busy),
        .o_wr             (w_wr),
        .o_done           (o_done),
        .o_port_out       (o_port_out),
        .o_report         (o_report),
        .o_reported_state (o_reported_state),
        .o_is_locked      (o_is_locked)
    );

endmodule

[hw/rtl/pmc_checker.sv]
// Port-level assertions for the point motor controller, bound to the top level.
module pmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_report,
    input logic [2:0] o_reported_state,
    input logic       o_is_locked
);

    a_report_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report |-> o_done)
        else $error("report outside a result cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not raise busy");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe not at end of busy");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> ($stable(o_reported_state) && $stable(o_is_locked)))
        else $error("state changed without a result");

endmodule

bind point_motor_controller_top pmc_checker u_pmc_checker (.*);
